>>> sv/esu_pkg.sv
// shared types, constants and a helper function for the escape sequence unescaper
package esu_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChB         = 8'h62;
	localparam logic [7:0] ChN         = 8'h6E;
	localparam logic [7:0] ChF         = 8'h66;
	localparam logic [7:0] ChR         = 8'h72;
	localparam logic [7:0] ChT         = 8'h74;
	localparam logic [7:0] ChLowerU    = 8'h75;
	localparam logic [7:0] ChUpperU    = 8'h55;

	localparam logic [3:0] ShortDigits = 4'd4;
	localparam logic [3:0] LongDigits  = 4'd8;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_DANGLING  = 3'd1,
		ERR_TRUNCATED = 3'd2,
		ERR_BAD_VALUE = 3'd3,
		ERR_ILLEGAL   = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		MODE_TEXT = 3'b001,
		MODE_ESC  = 3'b010,
		MODE_HEX  = 3'b100
	} mode_t;

	// one queued command: up to four results for a single input byte
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            data;
		err_t            err;
		logic            eos;
	} cmd_t;

	// bit 4 set when the character is not a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

>>> sv/esu_front.sv
// front end: accepts raw bytes, tracks escape state and builds result commands
module esu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            cmd_push,
	output esu_pkg::cmd_t   cmd
);
	import esu_pkg::*;

	mode_t       mode_q, mode_n;
	logic [3:0]  digits_q, digits_n;
	logic [31:0] code_q, code_n;
	logic        bad_q, bad_n;
	logic        err_q, err_n;
	logic        has_res;
	logic [4:0]  hex;
	logic [31:0] v;

	assign hex = hex_decode(in_byte);
	assign v   = {code_q[27:0], hex[4] ? 4'h0 : hex[3:0]};

	always_comb begin
		mode_n   = mode_q;
		digits_n = digits_q;
		code_n   = code_q;
		bad_n    = bad_q;
		err_n    = err_q;
		has_res  = 1'b0;
		cmd      = '0;
		cmd.err  = ERR_NONE;
		if (!err_q) begin
			case (mode_q)
				MODE_ESC: begin
					mode_n   = MODE_TEXT;
					has_res  = 1'b1;
					cmd.data = 1'b1;
					case (in_byte)
						ChB:         cmd.bytes[0] = 8'h08;
						ChN:         cmd.bytes[0] = 8'h0A;
						ChF:         cmd.bytes[0] = 8'h0C;
						ChR:         cmd.bytes[0] = 8'h0D;
						ChT:         cmd.bytes[0] = 8'h09;
						ChQuote:     cmd.bytes[0] = 8'h22;
						ChBackslash: cmd.bytes[0] = 8'h5C;
						ChLowerU, ChUpperU: begin
							mode_n   = MODE_HEX;
							digits_n = (in_byte == ChLowerU) ? ShortDigits : LongDigits;
							code_n   = '0;
							bad_n    = 1'b0;
							cmd.data = 1'b0;
							has_res  = in_last;
							if (in_last) begin
								cmd.err = ERR_TRUNCATED;
								err_n   = 1'b1;
							end
						end
						default: begin
							cmd.data = 1'b0;
							cmd.err  = ERR_ILLEGAL;
							err_n    = 1'b1;
						end
					endcase
				end
				MODE_HEX: begin
					bad_n    = bad_q | hex[4];
					code_n   = v;
					digits_n = digits_q - 4'd1;
					if (digits_n == 4'd0) begin
						mode_n  = MODE_TEXT;
						has_res = 1'b1;
						if (bad_n || v > 32'h0010_FFFF || (v >= 32'hD800 && v <= 32'hDFFF)) begin
							cmd.err = ERR_BAD_VALUE;
							err_n   = 1'b1;
						end else begin
							cmd.data = 1'b1;
							if (v < 32'h80) begin
								cmd.bytes[0] = v[7:0];
								cmd.last_idx = 2'd0;
							end else if (v < 32'h800) begin
								cmd.bytes[0] = {3'b110, v[10:6]};
								cmd.bytes[1] = {2'b10, v[5:0]};
								cmd.last_idx = 2'd1;
							end else if (v < 32'h1_0000) begin
								cmd.bytes[0] = {4'b1110, v[15:12]};
								cmd.bytes[1] = {2'b10, v[11:6]};
								cmd.bytes[2] = {2'b10, v[5:0]};
								cmd.last_idx = 2'd2;
							end else begin
								cmd.bytes[0] = {5'b11110, v[20:18]};
								cmd.bytes[1] = {2'b10, v[17:12]};
								cmd.bytes[2] = {2'b10, v[11:6]};
								cmd.bytes[3] = {2'b10, v[5:0]};
								cmd.last_idx = 2'd3;
							end
						end
					end else if (in_last) begin
						has_res = 1'b1;
						cmd.err = ERR_TRUNCATED;
						err_n   = 1'b1;
					end
				end
				default: begin
					if (in_byte == ChBackslash) begin
						mode_n = MODE_ESC;
						if (in_last) begin
							has_res = 1'b1;
							cmd.err = ERR_DANGLING;
							err_n   = 1'b1;
						end
					end else begin
						has_res      = 1'b1;
						cmd.data     = 1'b1;
						cmd.bytes[0] = in_byte;
					end
				end
			endcase
		end
		if (in_last) begin
			cmd.eos  = 1'b1;
			mode_n   = MODE_TEXT;
			digits_n = '0;
			code_n   = '0;
			bad_n    = 1'b0;
			err_n    = 1'b0;
		end
	end

	assign cmd_push = accept && (has_res || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_TEXT;
			digits_q <= '0;
			code_q   <= '0;
			bad_q    <= 1'b0;
			err_q    <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_n;
			digits_q <= digits_n;
			code_q   <= code_n;
			bad_q    <= bad_n;
			err_q    <= err_n;
		end
	end

	property p_latched_quiet;
		@(posedge clk) disable iff (!arst_n) (err_q && !in_last) |-> !cmd_push;
	endproperty
	a_latched_quiet: assert property (p_latched_quiet) else $error("output after latched error");

	property p_data_no_err;
		@(posedge clk) disable iff (!arst_n) cmd_push && cmd.data |-> cmd.err == ERR_NONE;
	endproperty
	a_data_no_err: assert property (p_data_no_err) else $error("data command carries error");

endmodule

>>> sv/esu_queue.sv
// short command queue between the front end and the result emitter
module esu_queue #(
	parameter int unsigned DEPTH = esu_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  esu_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output esu_pkg::cmd_t rdata
);
	import esu_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [CntW-1:0] cnt_q;

	assign full     = (cnt_q == CntMax);
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PtrMax) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PtrMax) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) push |-> (!full || pop);
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) pop |-> nonempty;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

endmodule

>>> sv/esu_back.sv
// back end: expands queued commands into result transactions, one per cycle while results are popped
module esu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_avail,
	input  esu_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          end_of_string,
	output logic [2:0]    error_code
);
	import esu_pkg::*;

	logic       out_valid_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_end;
	logic [7:0] byte_q;
	logic       bvalid_q;
	logic       eos_q;
	err_t       err_q;

	assign empty   = !out_valid_q;
	assign load    = cmd_avail && (!out_valid_q || pop);
	assign at_end  = (idx_q == cmd.last_idx);
	assign cmd_pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= cmd.data ? cmd.bytes[idx_q] : 8'h00;
			bvalid_q <= cmd.data;
			eos_q    <= cmd.eos && at_end;
			err_q    <= cmd.err;
		end
	end

	assign out_byte      = byte_q;
	assign byte_valid    = bvalid_q;
	assign end_of_string = eos_q;
	assign error_code    = err_q;

	property p_idx_in_range;
		@(posedge clk) disable iff (!arst_n) cmd_avail |-> idx_q <= cmd.last_idx;
	endproperty
	a_idx_in_range: assert property (p_idx_in_range) else $error("result index past command");

	property p_idle_idx;
		@(posedge clk) disable iff (!arst_n) !cmd_avail |-> idx_q == 2'd0;
	endproperty
	a_idle_idx: assert property (p_idle_idx) else $error("index left over without command");

endmodule

>>> sv/escape_sequence_unescaper.sv
// top level of the escape sequence unescaper: front end, command queue and emitter
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  input    | push / full           | in_byte, in_last
//  result   | empty / pop           | out_byte, byte_valid, end_of_string, error_code
//
// one input byte is taken per cycle while the command queue has room
// each byte yields zero to four results; the emitter hands out one result per cycle while results are popped
// a \U or \u escape that decodes to n UTF-8 bytes gives n results, all expanded by the emitter from one queued command
// the queue and result register let input continue while results wait to be popped
// arst_n clears escape state, queue pointers and count, and the emitter's valid flag and index
module escape_sequence_unescaper #(
	parameter int unsigned QUEUE_DEPTH = esu_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_string,
	output logic [2:0] error_code
);
	import esu_pkg::*;

	logic accept;
	logic cmd_push;
	logic cmd_pop;
	logic cmd_avail;
	cmd_t cmd_in;
	cmd_t cmd_out;

	assign accept = push && !full;

	esu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	esu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.wdata    (cmd_in),
		.full     (full),
		.pop      (cmd_pop),
		.nonempty (cmd_avail),
		.rdata    (cmd_out)
	);

	esu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_avail     (cmd_avail),
		.cmd           (cmd_out),
		.cmd_pop       (cmd_pop),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string),
		.error_code    (error_code)
	);

endmodule

>>> tb/sv/tb_escape_sequence_unescaper.sv
// testbench for the escape sequence unescaper: directed and random strings, checked per transaction
`timescale 1ns / 100ps
module tb_escape_sequence_unescaper;
	import esu_pkg::*;

	localparam int unsigned CycleLimit = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       eos;
		logic [2:0] err;
	} result_t;

	typedef logic [7:0] bytes_t[$];

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_string;
	logic [2:0] error_code;

	// unescaper state as predicted
	mode_t       parse_mode = MODE_TEXT;
	logic [3:0]  digits_left = 4'd0;
	logic [31:0] code_value = 32'd0;
	logic        hex_bad = 1'b0;
	logic        err_latched = 1'b0;

	result_t     unescaped_q[$];
	result_t     head;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int unsigned rx_hold = 0;

	escape_sequence_unescaper dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.in_last(in_last),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.end_of_string(end_of_string),
		.error_code(error_code)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] c);
		case (c)
			ChB, ChN, ChF, ChR, ChT, ChQuote, ChBackslash, ChLowerU, ChUpperU: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic note_result(input result_t r);
		unescaped_q.insert(unescaped_q.size(), r);
	endtask

	task automatic expect_data(input logic [7:0] b);
		note_result(result_t'{b, 1'b1, 1'b0, ERR_NONE});
	endtask

	task automatic expect_error(input err_t e);
		note_result(result_t'{8'h00, 1'b0, 1'b0, e});
		err_latched = 1'b1;
	endtask

	task automatic emit_code_point();
		logic [31:0] v;
		v = code_value;
		if (hex_bad || v > 32'h10FFFF || (v >= 32'hD800 && v <= 32'hDFFF)) begin
			expect_error(ERR_BAD_VALUE);
		end else if (v < 32'h80) begin
			expect_data(v[7:0]);
		end else if (v < 32'h800) begin
			expect_data(8'hC0 | 8'(v >> 6));
			expect_data(8'h80 | {2'b00, v[5:0]});
		end else if (v < 32'h10000) begin
			expect_data(8'hE0 | 8'(v >> 12));
			expect_data(8'h80 | {2'b00, v[11:6]});
			expect_data(8'h80 | {2'b00, v[5:0]});
		end else begin
			expect_data(8'hF0 | 8'(v >> 18));
			expect_data(8'h80 | {2'b00, v[17:12]});
			expect_data(8'h80 | {2'b00, v[11:6]});
			expect_data(8'h80 | {2'b00, v[5:0]});
		end
	endtask

	// expected results for one accepted byte
	task automatic unescape_byte(input logic [7:0] c, input logic last);
		int      n_start;
		int      h;
		result_t r;
		n_start = unescaped_q.size();
		if (!err_latched) begin
			case (parse_mode)
				MODE_ESC: begin
					parse_mode = MODE_TEXT;
					case (c)
						ChB: expect_data(8'h08);
						ChN: expect_data(8'h0A);
						ChF: expect_data(8'h0C);
						ChR: expect_data(8'h0D);
						ChT: expect_data(8'h09);
						ChQuote, ChBackslash: expect_data(c);
						ChLowerU, ChUpperU: begin
							parse_mode = MODE_HEX;
							digits_left = (c == ChLowerU) ? ShortDigits : LongDigits;
							code_value = 32'd0;
							hex_bad = 1'b0;
							if (last) expect_error(ERR_TRUNCATED);
						end
						default: expect_error(ERR_ILLEGAL);
					endcase
				end
				MODE_HEX: begin
					h = nibble_of(c);
					if (h < 0) hex_bad = 1'b1;
					code_value = {code_value[27:0], (h < 0) ? 4'd0 : 4'(h)};
					digits_left = digits_left - 4'd1;
					if (digits_left == 4'd0) begin
						parse_mode = MODE_TEXT;
						emit_code_point();
					end else if (last) begin
						expect_error(ERR_TRUNCATED);
					end
				end
				default: begin
					if (c == ChBackslash) begin
						parse_mode = MODE_ESC;
						if (last) expect_error(ERR_DANGLING);
					end else begin
						expect_data(c);
					end
				end
			endcase
		end
		if (last) begin
			if (unescaped_q.size() == n_start)
				note_result(result_t'{8'h00, 1'b0, 1'b0, ERR_NONE});
			r = unescaped_q.pop_back();
			r.eos = 1'b1;
			note_result(r);
			parse_mode = MODE_TEXT;
			digits_left = 4'd0;
			code_value = 32'd0;
			hex_bad = 1'b0;
			err_latched = 1'b0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (full);
		unescape_byte(b, last);
		items_sent++;
	endtask

	task automatic send_string(input bytes_t s);
		foreach (s[i]) send_byte(s[i], i == s.size() - 1);
	endtask

	// sender pauses until every expected transaction has come out
	task automatic wait_results_done();
		push <= 1'b0;
		@(posedge clk);
		while (unescaped_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + 8'(nib);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
	endfunction

	function automatic logic [31:0] pick_code_point();
		logic [31:0] edges[13];
		edges = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hD800, 32'hDFFF,
			32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000};
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 32'h7F);
			2: return $urandom_range(32'h80, 32'h7FF);
			3: return $urandom_range(32'hE000, 32'hFFFF);
			4, 5, 6: return $urandom_range(32'h10000, 32'h10FFFF);
			7: return $urandom_range(32'hD800, 32'hDFFF);
			8: return $urandom_range(32'h110000, 32'hFFFFFFFF);
			default: return $urandom_range(0, 1) ? edges[$urandom_range(0, 12)] : 32'hFFFFFFFF;
		endcase
	endfunction

	task automatic add_token(inout bytes_t s);
		int unsigned kind;
		int unsigned ndig;
		int unsigned bad_pos;
		logic [7:0]  b;
		logic [31:0] v;
		bit          long_form;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			do b = 8'($urandom_range(0, 255)); while (b == ChBackslash);
			s.insert(s.size(), b);
		end else if (kind < 65) begin
			s.insert(s.size(), ChBackslash);
			case ($urandom_range(0, 6))
				0: s.insert(s.size(), ChB);
				1: s.insert(s.size(), ChN);
				2: s.insert(s.size(), ChF);
				3: s.insert(s.size(), ChR);
				4: s.insert(s.size(), ChT);
				5: s.insert(s.size(), ChQuote);
				default: s.insert(s.size(), ChBackslash);
			endcase
		end else if (kind < 92) begin
			long_form = 1'($urandom_range(0, 1));
			ndig = long_form ? 8 : 4;
			v = pick_code_point();
			if (!long_form) v = {16'h0000, v[15:0]};
			bad_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ndig - 1) : ndig;
			s.insert(s.size(), ChBackslash);
			s.insert(s.size(), long_form ? ChUpperU : ChLowerU);
			for (int i = int'(ndig) - 1; i >= 0; i--) begin
				if (i == int'(bad_pos)) begin
					do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
					s.insert(s.size(), b);
				end else begin
					s.insert(s.size(), hex_char(v[4*i +: 4]));
				end
			end
		end else begin
			do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
			s.insert(s.size(), ChBackslash);
			s.insert(s.size(), b);
		end
	endtask

	task automatic send_random_strings(input int unsigned n_items);
		bytes_t      s;
		int unsigned ntok;
		int unsigned stop_at;
		logic [7:0]  b;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			s = {};
			if ($urandom_range(0, 19) == 0) begin
				// noise: raw bytes with plenty of backslashes
				repeat ($urandom_range(1, 8)) begin
					b = ($urandom_range(0, 3) == 0) ? ChBackslash : 8'($urandom_range(0, 255));
					s.insert(s.size(), b);
				end
			end else begin
				ntok = $urandom_range(1, 6);
				repeat (ntok) add_token(s);
				if ($urandom_range(0, 99) < 15) s = s[0:$urandom_range(0, s.size() - 1)];
			end
			send_string(s);
		end
	endtask

	task automatic test_simple_escapes();
		send_string('{ChBackslash, ChB, ChBackslash, ChN, ChBackslash, ChF, ChBackslash, ChR,
			ChBackslash, ChQuote, ChBackslash, ChBackslash, ChBackslash, ChT});
		wait_results_done();
	endtask

	task automatic test_escape_errors();
		send_string('{ChBackslash});
		send_string('{ChBackslash, ChLowerU});
		send_string('{ChBackslash, 8'hFF, 8'h00});
		send_string('{ChBackslash, ChLowerU, 8'h64, 8'h38, 8'h30, 8'h30});
		wait_results_done();
	endtask

	task automatic test_random_with_gaps();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_random_strings(280);
		wait_results_done();
	endtask

	task automatic test_fill_and_stall();
		tx_idle = 1'b0;
		rx_hold = 300;
		send_random_strings(40);
		wait_results_done();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_streaming();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_random_strings(110);
		wait_results_done();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// result side: random pop gaps and one long hold-off on request
	initial begin : result_drain
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			gap = rx_idle ? $urandom_range(0, 7) : 0;
			if (rx_hold != 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (unescaped_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected transaction: expected none, got %02h %b %b %0d",
					$time, out_byte, byte_valid, end_of_string, error_code);
			end else begin
				head = unescaped_q.pop_front();
				if (out_byte !== head.data) begin
					fail_count++;
					$display("%0t: out_byte expected %02h got %02h", $time, head.data, out_byte);
				end
				if (byte_valid !== head.valid) begin
					fail_count++;
					$display("%0t: byte_valid expected %b got %b", $time, head.valid, byte_valid);
				end
				if (end_of_string !== head.eos) begin
					fail_count++;
					$display("%0t: end_of_string expected %b got %b", $time, head.eos, end_of_string);
				end
				if (error_code !== head.err) begin
					fail_count++;
					$display("%0t: error_code expected %0d got %0d", $time, head.err, error_code);
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_simple_escapes();
		test_escape_errors();
		test_random_with_gaps();
		test_fill_and_stall();
		test_random_streaming();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && unescaped_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
